@@ rtl/core/serial_settable_time_of_day_clock_defines.svh @@
// ----------------------------------------------------------------------------
// serial_settable_time_of_day_clock_defines
// assertion macros for the time-of-day clock rtl
// ----------------------------------------------------------------------------
`ifndef SERIAL_SETTABLE_TIME_OF_DAY_CLOCK_DEFINES_SVH
`define SERIAL_SETTABLE_TIME_OF_DAY_CLOCK_DEFINES_SVH

// same-cycle implication
`define SSTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sstc assertion failed");

// next-cycle implication
`define SSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sstc assertion failed");

`endif

@@ rtl/core/sstc_pkg.sv @@
// ----------------------------------------------------------------------------
// sstc_pkg
// types and constants for the serial settable time-of-day clock
// ----------------------------------------------------------------------------
package sstc_pkg;

    localparam int LINE_LIMIT_DEF = 11;
    localparam int NUM_DIGITS     = 6;
    localparam int DIGIT_BASE     = 10;
    localparam int HOURS_PER_DAY  = 24;
    localparam int MINS_PER_HOUR  = 60;
    localparam int SECS_PER_MIN   = 60;
    localparam int RESET_HOURS    = 21;
    localparam int RESET_MINUTES  = 13;
    localparam int HHMM_DIGITS    = 4;

    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic {
        MODE_BYTE = 1'b0,
        MODE_TICK = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_OK    = 2'd1,
        KIND_FMT   = 2'd2,
        KIND_RANGE = 2'd3
    } t_report_kind;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_report_kind report_kind;
        logic [4:0]   hours;
        logic [5:0]   minutes;
        logic [5:0]   seconds;
        logic         dot_on;
    } t_out_item;

    // parsed command line handed from the line buffer to the timekeeper
    typedef struct packed {
        logic       end_line;
        logic       fmt_err;
        logic       range_err;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
    } t_line_cmd;

endpackage

@@ rtl/core/serial_settable_time_of_day_clock.sv @@
// ----------------------------------------------------------------------------
// serial_settable_time_of_day_clock
// 24-hour clock with one-second tick and serial HH:MM[:SS] time set
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless stalled: a transfer is registered in
// the input stage, processed in one pass through the line buffer and
// timekeeper, and its report (if any) is loaded into the result register as
// the item leaves the input stage. The input stage stalls while it holds an
// item and the result register is full and stalled downstream.
module serial_settable_time_of_day_clock #(
    parameter int LINE_LIMIT = sstc_pkg::LINE_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sstc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sstc_pkg::t_out_item o_out_item
);

    `include "serial_settable_time_of_day_clock_defines.svh"

    logic                r_in_valid;
    sstc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    sstc_pkg::t_out_item r_out_item;

    logic                advance, has_result;
    sstc_pkg::t_line_cmd cmd;
    sstc_pkg::t_out_item result;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    sstc_line_buf #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in_item),
        .o_cmd   (cmd)
    );

    sstc_timekeeper u_timekeeper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_item       (r_in_item),
        .i_cmd        (cmd),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `SSTC_ASSERT_NOW(a_time_in_range, i_clk, i_rst_n, o_out_valid,
        (o_out_item.hours < 5'(sstc_pkg::HOURS_PER_DAY))
        && (o_out_item.minutes < 6'(sstc_pkg::MINS_PER_HOUR))
        && (o_out_item.seconds < 6'(sstc_pkg::SECS_PER_MIN)))
    `SSTC_ASSERT_NEXT(a_tick_reports, i_clk, i_rst_n,
        advance && (r_in_item.mode == sstc_pkg::MODE_TICK),
        r_out_valid && (r_out_item.report_kind == sstc_pkg::KIND_TICK))
    `SSTC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_in_valid && r_out_valid && i_out_stall)

endmodule

@@ rtl/core/sstc_line_buf.sv @@
// ----------------------------------------------------------------------------
// sstc_line_buf
// collects received bytes into a command line and parses the digits
// ----------------------------------------------------------------------------
module sstc_line_buf #(
    parameter int LINE_LIMIT = sstc_pkg::LINE_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  sstc_pkg::t_in_item  i_item,
    output sstc_pkg::t_line_cmd o_cmd
);

    localparam int LW = $clog2(LINE_LIMIT + 1);
    localparam int DW = $clog2(sstc_pkg::NUM_DIGITS + 1);

    logic [LW-1:0] r_len, n_len;
    logic [DW-1:0] r_total, n_total;
    logic [sstc_pkg::NUM_DIGITS-1:0][3:0] r_digits;

    logic       is_byte, is_eol, is_digit, keep, store;
    logic [6:0] hh, mm, ss;

    assign is_byte  = (i_item.mode == sstc_pkg::MODE_BYTE);
    assign is_eol   = (i_item.rx_byte == sstc_pkg::CH_LF) || (i_item.rx_byte == sstc_pkg::CH_CR);
    assign is_digit = i_item.rx_byte inside {[sstc_pkg::CH_ZERO:sstc_pkg::CH_NINE]};
    assign keep     = is_byte && !is_eol && (r_len < LW'(LINE_LIMIT));
    assign store    = keep && is_digit && (r_total < DW'(sstc_pkg::NUM_DIGITS));

    always_comb begin
        n_len   = r_len;
        n_total = r_total;
        if (is_byte && is_eol && r_len != '0) begin
            n_len   = '0;
            n_total = '0;
        end else if (keep) begin
            n_len = r_len + LW'(1);
            if (store) begin
                n_total = r_total + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_total <= '0;
        end else if (i_fire) begin
            r_len   <= n_len;
            r_total <= n_total;
        end
    end

    // digit store, no reset: entries at or above the count reach only results that a format error overrides
    always_ff @(posedge i_clk) begin
        if (i_fire && store) begin
            r_digits[r_total[DW-1:0]] <= i_item.rx_byte[3:0];
        end
    end

    // digit value times ten plus next digit
    function automatic logic [6:0] pair(input logic [3:0] a, input logic [3:0] b);
        pair = ({3'b0, a} << 3) + ({3'b0, a} << 1) + {3'b0, b};
    endfunction

    assign hh = pair(r_digits[0], r_digits[1]);
    assign mm = pair(r_digits[2], r_digits[3]);
    assign ss = (r_total == DW'(sstc_pkg::NUM_DIGITS)) ? pair(r_digits[4], r_digits[5]) : 7'd0;

    always_comb begin
        o_cmd.end_line  = is_byte && is_eol && (r_len != '0);
        o_cmd.fmt_err   = (r_total != DW'(sstc_pkg::HHMM_DIGITS))
                       && (r_total != DW'(sstc_pkg::NUM_DIGITS));
        o_cmd.range_err = (hh >= 7'(sstc_pkg::HOURS_PER_DAY))
                       || (mm >= 7'(sstc_pkg::MINS_PER_HOUR))
                       || (ss >= 7'(sstc_pkg::SECS_PER_MIN));
        o_cmd.hh        = hh[4:0];
        o_cmd.mm        = mm[5:0];
        o_cmd.ss        = ss[5:0];
    end

endmodule

@@ rtl/core/sstc_timekeeper.sv @@
// ----------------------------------------------------------------------------
// sstc_timekeeper
// time registers, tick cascade, time load and report selection
// ----------------------------------------------------------------------------
module sstc_timekeeper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  sstc_pkg::t_in_item  i_item,
    input  sstc_pkg::t_line_cmd i_cmd,
    output logic                o_has_result,
    output sstc_pkg::t_out_item o_result
);

    logic [4:0] r_hours, n_hours;
    logic [5:0] r_minutes, n_minutes;
    logic [5:0] r_seconds, n_seconds;
    logic       r_dot, n_dot;

    logic                   is_tick, sec_wrap, min_wrap, hour_wrap;
    sstc_pkg::t_report_kind kind;

    assign is_tick   = (i_item.mode == sstc_pkg::MODE_TICK);
    assign sec_wrap  = (r_seconds == 6'(sstc_pkg::SECS_PER_MIN - 1));
    assign min_wrap  = (r_minutes == 6'(sstc_pkg::MINS_PER_HOUR - 1));
    assign hour_wrap = (r_hours == 5'(sstc_pkg::HOURS_PER_DAY - 1));

    always_comb begin
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_dot     = r_dot;
        kind      = sstc_pkg::KIND_TICK;
        if (is_tick) begin
            n_dot     = ~r_dot;
            n_seconds = sec_wrap ? 6'd0 : r_seconds + 6'd1;
            if (sec_wrap) begin
                n_minutes = min_wrap ? 6'd0 : r_minutes + 6'd1;
                if (min_wrap) begin
                    n_hours = hour_wrap ? 5'd0 : r_hours + 5'd1;
                end
            end
        end else if (i_cmd.end_line) begin
            if (i_cmd.fmt_err) begin
                kind = sstc_pkg::KIND_FMT;
            end else if (i_cmd.range_err) begin
                kind = sstc_pkg::KIND_RANGE;
            end else begin
                kind      = sstc_pkg::KIND_OK;
                n_hours   = i_cmd.hh;
                n_minutes = i_cmd.mm;
                n_seconds = i_cmd.ss;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours   <= 5'(sstc_pkg::RESET_HOURS);
            r_minutes <= 6'(sstc_pkg::RESET_MINUTES);
            r_seconds <= 6'd0;
            r_dot     <= 1'b0;
        end else if (i_fire) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
            r_dot     <= n_dot;
        end
    end

    assign o_has_result         = is_tick || i_cmd.end_line;
    assign o_result.report_kind = kind;
    assign o_result.hours       = n_hours;
    assign o_result.minutes     = n_minutes;
    assign o_result.seconds     = n_seconds;
    assign o_result.dot_on      = n_dot;

endmodule
